>>> hw/rtl/ilt_pkg.sv
// Package for the indexed list table: field widths, mode and status codes,
// and the result record passed from the sequencer to the output stage.
// Depends on nothing; used by every module of the block.
package ilt_pkg;

  localparam int unsigned ModeW           = 3;
  localparam int unsigned IdxW            = 8;
  localparam int unsigned DataW           = 32;
  localparam int unsigned FoundW          = 9;
  localparam int unsigned CountW          = 9;
  localparam int unsigned StatusW         = 2;
  localparam int unsigned DefaultCapacity = 256;

  // Request modes; the two remaining codes are treated as no-ops.
  typedef enum logic [ModeW-1:0] {
    ModeAppend      = 3'd0,
    ModeRead        = 3'd1,
    ModeWrite       = 3'd2,
    ModeRemoveAt    = 3'd3,
    ModeFind        = 3'd4,
    ModeRemoveValue = 3'd5
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    StatOk       = 2'd0,
    StatRange    = 2'd1,
    StatNotFound = 2'd2,
    StatFull     = 2'd3
  } status_e;

  // One finished result as it leaves the sequencer.
  typedef struct packed {
    status_e             status;
    logic [DataW-1:0]    read_value;
    logic [FoundW-1:0]   found_index;
    logic [CountW-1:0]   entry_count;
    logic                is_empty;
  } result_t;

endpackage

>>> hw/rtl/indexed_list_table.sv
// Top level of the indexed list table: sequencer, entry memory and the
// output register. Depends on ilt_pkg, ilt_store and ilt_ctrl.
//
//   Channel | Direction | Handshake               | Payload
//   request | in        | in_valid_i / in_ready_o | mode_i, index_i, value_i
//   result  | out       | out_valid_o/out_ready_i | status_o, read_value_o,
//           |           |                         | found_index_o, entry_count_o,
//           |           |                         | is_empty_o
//
// Append, write, no-ops and index or full errors finish straight from the execute state;
// read waits for the registered read data; find reads the entries in order until a
// match or the end of the list; removal moves each later entry one place down, and
// removal by value first runs the search.
// rst_ni clears the count and the sequencer at once; entries need no clearing.
// A result waiting in the output register lets the next request be accepted.
module indexed_list_table #(
  parameter int unsigned CAPACITY = ilt_pkg::DefaultCapacity
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ilt_pkg::ModeW-1:0]  mode_i,
  input  logic [ilt_pkg::IdxW-1:0]   index_i,
  input  logic [ilt_pkg::DataW-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [ilt_pkg::StatusW-1:0] status_o,
  output logic [ilt_pkg::DataW-1:0]  read_value_o,
  output logic [ilt_pkg::FoundW-1:0] found_index_o,
  output logic [ilt_pkg::CountW-1:0] entry_count_o,
  output logic                       is_empty_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);

  logic                      we;
  logic [AddrW-1:0]          waddr;
  logic [ilt_pkg::DataW-1:0] wdata;
  logic                      re;
  logic [AddrW-1:0]          raddr;
  logic [ilt_pkg::DataW-1:0] rdata;
  logic                      res_valid;
  logic                      res_ready;
  ilt_pkg::result_t          res;
  logic                      out_valid_q, out_valid_d;
  ilt_pkg::result_t          out_q;

  ilt_ctrl #(
    .Capacity (CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .mode_i      (mode_i),
    .index_i     (index_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata)
  );

  ilt_store #(
    .Depth (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Output register: takes a new result when empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_q.status;
  assign read_value_o  = out_q.read_value;
  assign found_index_o = out_q.found_index;
  assign entry_count_o = out_q.entry_count;
  assign is_empty_o    = out_q.is_empty;

endmodule

>>> hw/rtl/ilt_store.sv
// Entry memory of the indexed list table: one write port, one read port,
// registered read data. Depends on ilt_pkg for the data width and the default depth.
module ilt_store #(
  parameter int unsigned Depth = ilt_pkg::DefaultCapacity,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AddrW-1:0]          waddr_i,
  input  logic [ilt_pkg::DataW-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AddrW-1:0]          raddr_i,
  output logic [ilt_pkg::DataW-1:0] rdata_o
);

  logic [ilt_pkg::DataW-1:0] mem_q [Depth];
  logic [ilt_pkg::DataW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with the data registered.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ilt_ctrl.sv
// Sequencer of the indexed list table: decodes a request, walks the entry
// memory for search and removal with one shared compare, and keeps the count.
// Depends on ilt_pkg and drives the memory ports of ilt_store.
module ilt_ctrl #(
  parameter int unsigned Capacity = ilt_pkg::DefaultCapacity,
  localparam int unsigned AddrW = $clog2(Capacity),
  localparam int unsigned CntW  = $clog2(Capacity + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Request side.
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  logic [ilt_pkg::ModeW-1:0] mode_i,
  input  logic [ilt_pkg::IdxW-1:0]  index_i,
  input  logic [ilt_pkg::DataW-1:0] value_i,
  // Result side.
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output ilt_pkg::result_t          res_o,
  // Memory ports.
  output logic                      we_o,
  output logic [AddrW-1:0]          waddr_o,
  output logic [ilt_pkg::DataW-1:0] wdata_o,
  output logic                      re_o,
  output logic [AddrW-1:0]          raddr_o,
  input  logic [ilt_pkg::DataW-1:0] rdata_i
);

  // Wide enough for the index, the count and the found position.
  localparam int unsigned WideW = (CntW > ilt_pkg::FoundW) ? CntW : ilt_pkg::FoundW;

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StReadWait,
    StScan,
    StShift,
    StDone
  } state_e;

  state_e                       state_q, state_d;
  ilt_pkg::mode_e               mode_q, mode_d;
  logic [ilt_pkg::IdxW-1:0]     idx_q, idx_d;
  logic [ilt_pkg::DataW-1:0]    val_q, val_d;
  ilt_pkg::status_e             status_q, status_d;
  logic [ilt_pkg::DataW-1:0]    read_q, read_d;
  logic [ilt_pkg::FoundW-1:0]   found_q, found_d;
  logic [CntW-1:0]              total_q, total_d;
  logic [CntW-1:0]              ptr_q, ptr_d;
  logic                         pend_q, pend_d;
  logic [AddrW-1:0]             paddr_q, paddr_d;

  logic [WideW-1:0]             idx_wide;
  logic [WideW-1:0]             total_wide;
  logic [WideW-1:0]             paddr_wide;
  logic                         in_range;
  logic                         match;

  assign idx_wide   = WideW'(idx_q);
  assign total_wide = WideW'(total_q);
  assign paddr_wide = WideW'(paddr_q);
  // The count never exceeds the capacity, so this bounds the index too.
  assign in_range   = idx_wide < total_wide;
  // The one shared comparator: stored entry in flight against the key.
  assign match      = pend_q && (rdata_i == val_q);

  // Next-state and memory control.
  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    idx_d    = idx_q;
    val_d    = val_q;
    status_d = status_q;
    read_d   = read_q;
    found_d  = found_q;
    total_d  = total_q;
    ptr_d    = ptr_q;
    pend_d   = pend_q;
    paddr_d  = paddr_q;
    we_o     = 1'b0;
    waddr_o  = '0;
    wdata_o  = val_q;
    re_o     = 1'b0;
    raddr_o  = '0;

    case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          mode_d   = ilt_pkg::mode_e'(mode_i);
          idx_d    = index_i;
          val_d    = value_i;
          status_d = ilt_pkg::StatOk;
          read_d   = '1;
          found_d  = '1;
          state_d  = StExec;
        end
      end

      StExec: begin
        case (mode_q)
          ilt_pkg::ModeAppend: begin
            if (total_q == CntW'(Capacity)) begin
              status_d = ilt_pkg::StatFull;
            end else begin
              we_o    = 1'b1;
              waddr_o = total_q[AddrW-1:0];
              total_d = total_q + 1'b1;
            end
            state_d = StDone;
          end
          ilt_pkg::ModeRead: begin
            if (in_range) begin
              re_o    = 1'b1;
              raddr_o = idx_wide[AddrW-1:0];
              state_d = StReadWait;
            end else begin
              status_d = ilt_pkg::StatRange;
              state_d  = StDone;
            end
          end
          ilt_pkg::ModeWrite: begin
            if (in_range) begin
              we_o    = 1'b1;
              waddr_o = idx_wide[AddrW-1:0];
            end else begin
              status_d = ilt_pkg::StatRange;
            end
            state_d = StDone;
          end
          ilt_pkg::ModeRemoveAt: begin
            if (in_range) begin
              ptr_d   = idx_wide[CntW-1:0] + 1'b1;
              pend_d  = 1'b0;
              state_d = StShift;
            end else begin
              status_d = ilt_pkg::StatRange;
              state_d  = StDone;
            end
          end
          ilt_pkg::ModeFind, ilt_pkg::ModeRemoveValue: begin
            ptr_d   = '0;
            pend_d  = 1'b0;
            state_d = StScan;
          end
          default: begin
            state_d = StDone;
          end
        endcase
      end

      StReadWait: begin
        read_d  = rdata_i;
        state_d = StDone;
      end

      // Read entries in order; each datum is compared with the key when its registered read data arrives.
      StScan: begin
        if (match) begin
          found_d = paddr_wide[ilt_pkg::FoundW-1:0];
          pend_d  = 1'b0;
          if (mode_q == ilt_pkg::ModeRemoveValue) begin
            ptr_d   = CntW'(paddr_q) + 1'b1;
            state_d = StShift;
          end else begin
            state_d = StDone;
          end
        end else if (ptr_q < total_q) begin
          re_o    = 1'b1;
          raddr_o = ptr_q[AddrW-1:0];
          pend_d  = 1'b1;
          paddr_d = ptr_q[AddrW-1:0];
          ptr_d   = ptr_q + 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          status_d = ilt_pkg::StatNotFound;
          state_d  = StDone;
        end
      end

      // Move each later entry one place down: read at ptr, then write the registered read data to the address below.
      StShift: begin
        if (pend_q) begin
          we_o    = 1'b1;
          waddr_o = paddr_q - AddrW'(1);
          wdata_o = rdata_i;
        end
        if (ptr_q < total_q) begin
          re_o    = 1'b1;
          raddr_o = ptr_q[AddrW-1:0];
          pend_d  = 1'b1;
          paddr_d = ptr_q[AddrW-1:0];
          ptr_d   = ptr_q + 1'b1;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          total_d = total_q - 1'b1;
          state_d = StDone;
        end
      end

      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and registered request and result fields.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      mode_q   <= ilt_pkg::ModeAppend;
      idx_q    <= '0;
      val_q    <= '0;
      status_q <= ilt_pkg::StatOk;
      read_q   <= '0;
      found_q  <= '0;
      total_q  <= '0;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
      paddr_q  <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      idx_q    <= idx_d;
      val_q    <= val_d;
      status_q <= status_d;
      read_q   <= read_d;
      found_q  <= found_d;
      total_q  <= total_d;
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
      paddr_q  <= paddr_d;
    end
  end

  // Result record; the count is already updated when StDone is reached.
  assign req_ready_o          = (state_q == StIdle);
  assign res_valid_o          = (state_q == StDone);
  assign res_o.status         = status_q;
  assign res_o.read_value     = read_q;
  assign res_o.found_index    = found_q;
  assign res_o.entry_count    = total_wide[ilt_pkg::CountW-1:0];
  assign res_o.is_empty       = (total_q == '0);

endmodule

>>> hw/rtl/ilt_checker.sv
// Port-level checker for the indexed list table, bound to the top level.
// Depends on ilt_pkg for the status codes and the port widths.
module ilt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [ilt_pkg::StatusW-1:0] status_o,
  input logic [ilt_pkg::DataW-1:0]   read_value_o,
  input logic [ilt_pkg::FoundW-1:0]  found_index_o,
  input logic [ilt_pkg::CountW-1:0]  entry_count_o,
  input logic                        is_empty_o
);

  // One request at a time: after an accepted request the block is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while a previous one is in progress");

  // The empty flag agrees with the count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (entry_count_o == '0)))
    else $error("empty flag disagrees with entry count");

  // Every failed request reports minus one as its read value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ilt_pkg::StatOk) |-> (read_value_o == '1))
    else $error("failed request carries a read value");

  // A missing value reports minus one as its position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ilt_pkg::StatNotFound) |-> (found_index_o == '1))
    else $error("value not found but a position is reported");

  // A stalled result stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o))
    else $error("stalled result changed or dropped");

endmodule

bind indexed_list_table ilt_checker u_ilt_checker (.*);

>>> tb/indexed_list_table_test.sv
`timescale 1ns / 100ps
// Testbench for indexed_list_table: sends list requests, keeps a shadow copy
// of the list and checks every result field against it.
// Depends on ilt_pkg and the indexed_list_table RTL.
module indexed_list_table_test;

  localparam int unsigned Capacity   = ilt_pkg::DefaultCapacity;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TailCycles = 300;
  localparam int unsigned ListTarget = 24;
  localparam int unsigned RandomRuns = 64;

  // The two mode codes that the block treats as no-ops.
  localparam logic [ilt_pkg::ModeW-1:0]  ModeSpareLo = 3'd6;
  localparam logic [ilt_pkg::ModeW-1:0]  ModeSpareHi = 3'd7;
  localparam logic [ilt_pkg::DataW-1:0]  NoData      = '1;
  localparam logic [ilt_pkg::FoundW-1:0] NoIndex     = '1;
  localparam logic [ilt_pkg::DataW-1:0]  MinValue    = 32'h8000_0000;
  localparam logic [ilt_pkg::DataW-1:0]  MaxValue    = 32'h7FFF_FFFF;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic [ilt_pkg::ModeW-1:0]    mode_i;
  logic [ilt_pkg::IdxW-1:0]     index_i;
  logic [ilt_pkg::DataW-1:0]    value_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic [ilt_pkg::StatusW-1:0]  status_o;
  logic [ilt_pkg::DataW-1:0]    read_value_o;
  logic [ilt_pkg::FoundW-1:0]   found_index_o;
  logic [ilt_pkg::CountW-1:0]   entry_count_o;
  logic                         is_empty_o;

  // Shadow copy of the list and the results still owed by the block.
  logic [ilt_pkg::DataW-1:0] list_entries [Capacity];
  int unsigned               list_length    = 0;
  ilt_pkg::result_t          awaited_results [$];
  int unsigned               error_count    = 0;
  int unsigned               idle_cycles    = 0;
  int unsigned               send_idle_pct  = 0;
  int unsigned               recv_stall_pct = 0;

  indexed_list_table #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .found_index_o(found_index_o),
    .entry_count_o(entry_count_o),
    .is_empty_o   (is_empty_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drops one entry from the shadow list and closes the gap.
  function automatic void remove_entry(int unsigned pos);
    for (int unsigned i = pos + 1; i < list_length; i++) begin
      list_entries[i - 1] = list_entries[i];
    end
    list_length--;
  endfunction

  // Applies one request to the shadow list and returns the result it owes.
  function automatic ilt_pkg::result_t apply_request(logic [ilt_pkg::ModeW-1:0] mode,
                                                     logic [ilt_pkg::IdxW-1:0] idx,
                                                     logic [ilt_pkg::DataW-1:0] val);
    ilt_pkg::result_t res;
    int               pos;
    res.status      = ilt_pkg::StatOk;
    res.read_value  = NoData;
    res.found_index = NoIndex;
    pos = -1;
    case (mode)
      ilt_pkg::ModeAppend: begin
        if (list_length >= Capacity) begin
          res.status = ilt_pkg::StatFull;
        end else begin
          list_entries[list_length] = val;
          list_length++;
        end
      end
      ilt_pkg::ModeRead: begin
        if (idx < list_length) res.read_value = list_entries[idx];
        else res.status = ilt_pkg::StatRange;
      end
      ilt_pkg::ModeWrite: begin
        if (idx < list_length) list_entries[idx] = val;
        else res.status = ilt_pkg::StatRange;
      end
      ilt_pkg::ModeRemoveAt: begin
        if (idx < list_length) remove_entry(idx);
        else res.status = ilt_pkg::StatRange;
      end
      ilt_pkg::ModeFind, ilt_pkg::ModeRemoveValue: begin
        for (int i = 0; i < int'(list_length) && pos < 0; i++) begin
          if (list_entries[i] == val) pos = i;
        end
        if (pos < 0) begin
          res.status = ilt_pkg::StatNotFound;
        end else begin
          res.found_index = pos[ilt_pkg::FoundW-1:0];
          if (mode == ilt_pkg::ModeRemoveValue) remove_entry(pos);
        end
      end
      default: ;
    endcase
    res.entry_count = list_length[ilt_pkg::CountW-1:0];
    res.is_empty    = (list_length == 0);
    return res;
  endfunction

  function automatic void check_field(string name, logic [ilt_pkg::DataW-1:0] want,
                                      logic [ilt_pkg::DataW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // Result checker: every accepted result is matched with the oldest request.
  always @(posedge clk_i) begin : check_results
    ilt_pkg::result_t expected;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d count %0d",
                 $time, status_o, entry_count_o);
        error_count++;
      end else begin
        expected = awaited_results.pop_front();
        check_field("status", ilt_pkg::DataW'(expected.status),
                    ilt_pkg::DataW'(status_o));
        check_field("read_value", expected.read_value, read_value_o);
        check_field("found_index", ilt_pkg::DataW'(expected.found_index),
                    ilt_pkg::DataW'(found_index_o));
        check_field("entry_count", ilt_pkg::DataW'(expected.entry_count),
                    ilt_pkg::DataW'(entry_count_o));
        check_field("is_empty", ilt_pkg::DataW'(expected.is_empty),
                    ilt_pkg::DataW'(is_empty_o));
      end
    end
  end

  // Result side: stall at random according to the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endfunction

  // Sends one request, with a random gap first, and records what it owes.
  task automatic send_request(logic [ilt_pkg::ModeW-1:0] mode,
                              logic [ilt_pkg::IdxW-1:0] idx,
                              logic [ilt_pkg::DataW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= mode;
    index_i    <= idx;
    value_i    <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    awaited_results.push_back(apply_request(mode, idx, val));
  endtask

  // Holds off new requests until the block has returned every result.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  // Errors on the empty list, extreme values, duplicates and no-op modes.
  task automatic test_directed();
    set_idling(0, 0);
    send_request(ilt_pkg::ModeRead, 8'd0, '0);
    send_request(ilt_pkg::ModeWrite, 8'd0, MaxValue);
    send_request(ilt_pkg::ModeRemoveAt, 8'd0, '0);
    send_request(ilt_pkg::ModeFind, 8'd0, '0);
    send_request(ilt_pkg::ModeRemoveValue, 8'd0, NoData);
    send_request(ModeSpareLo, 8'hFF, MaxValue);
    send_request(ilt_pkg::ModeAppend, 8'd0, MinValue);
    send_request(ilt_pkg::ModeAppend, 8'd0, MaxValue);
    send_request(ilt_pkg::ModeAppend, 8'd0, '0);
    send_request(ilt_pkg::ModeAppend, 8'd0, NoData);
    send_request(ilt_pkg::ModeAppend, 8'd0, MinValue);
    send_request(ilt_pkg::ModeRead, 8'd0, '0);
    send_request(ilt_pkg::ModeRead, 8'd4, '0);
    // One past the last entry, then the top of the index range.
    send_request(ilt_pkg::ModeRead, 8'd5, '0);
    send_request(ilt_pkg::ModeRead, 8'hFF, '0);
    send_request(ilt_pkg::ModeWrite, 8'd1, 32'hA5A5_5A5A);
    send_request(ilt_pkg::ModeWrite, 8'hFF, 32'h5A5A_A5A5);
    // The smallest value is stored twice; the first position must win.
    send_request(ilt_pkg::ModeFind, 8'd0, MinValue);
    send_request(ilt_pkg::ModeFind, 8'd0, 32'h1234_5678);
    send_request(ilt_pkg::ModeRemoveValue, 8'd0, MinValue);
    send_request(ilt_pkg::ModeRemoveAt, 8'd3, '0);
    send_request(ilt_pkg::ModeRemoveAt, 8'd0, '0);
    send_request(ModeSpareHi, 8'd0, '0);
    send_request(ilt_pkg::ModeRead, 8'd0, '0);
    wait_for_results();
  endtask

  // Fills the list to capacity, pushes against the full list, then empties it.
  task automatic test_capacity();
    logic [ilt_pkg::DataW-1:0] last_value;
    set_idling(32, 32);
    while (list_length < Capacity) send_request(ilt_pkg::ModeAppend, 8'd0, $urandom());
    repeat (3) send_request(ilt_pkg::ModeAppend, 8'd0, $urandom());
    last_value = $urandom();
    send_request(ilt_pkg::ModeWrite, 8'hFF, last_value);
    send_request(ilt_pkg::ModeRead, 8'hFF, '0);
    send_request(ilt_pkg::ModeFind, 8'd0, last_value);
    send_request(ilt_pkg::ModeRemoveAt, 8'd0, '0);
    send_request(ilt_pkg::ModeAppend, 8'd0, MinValue);
    send_request(ilt_pkg::ModeRemoveValue, 8'd0, list_entries[Capacity-1]);
    while (list_length > 0) begin
      if ($urandom_range(1))
        send_request(ilt_pkg::ModeRemoveAt,
                     ilt_pkg::IdxW'($urandom_range(list_length - 1)), '0);
      else
        send_request(ilt_pkg::ModeRemoveValue, 8'd0,
                     list_entries[$urandom_range(list_length - 1)]);
    end
    wait_for_results();
  endtask

  // Random requests on a short list, mostly aimed at valid positions, with
  // values drawn in part from the list.
  task automatic test_random(int unsigned count, int unsigned send_pct,
                             int unsigned recv_pct);
    int unsigned               pick;
    logic [ilt_pkg::ModeW-1:0] mode;
    logic [ilt_pkg::IdxW-1:0]  idx;
    logic [ilt_pkg::DataW-1:0] val;
    set_idling(send_pct, recv_pct);
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 28) begin
        mode = (list_length >= ListTarget) ? ilt_pkg::ModeRemoveAt : ilt_pkg::ModeAppend;
      end
      else if (pick < 46) mode = ilt_pkg::ModeRead;
      else if (pick < 60) mode = ilt_pkg::ModeWrite;
      else if (pick < 72) mode = ilt_pkg::ModeRemoveAt;
      else if (pick < 84) mode = ilt_pkg::ModeFind;
      else if (pick < 96) mode = ilt_pkg::ModeRemoveValue;
      else mode = $urandom_range(1) ? ModeSpareHi : ModeSpareLo;

      if (list_length > 0 && $urandom_range(99) < 80) begin
        idx = ilt_pkg::IdxW'($urandom_range(list_length - 1));
      end else begin
        idx = ilt_pkg::IdxW'($urandom_range(255));
      end

      pick = $urandom_range(99);
      if (pick < 45 && list_length > 0) begin
        val = list_entries[$urandom_range(list_length - 1)];
      end else if (pick < 70) begin
        case ($urandom_range(4))
          0: val = MinValue;
          1: val = MaxValue;
          2: val = '0;
          3: val = NoData;
          default: val = $urandom_range(7);
        endcase
      end else begin
        val = $urandom();
      end
      send_request(mode, idx, val);
    end
    wait_for_results();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    mode_i      <= '0;
    index_i     <= '0;
    value_i     <= '0;
    out_ready_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_capacity();
    test_random(RandomRuns, 0, 0);
    test_random(RandomRuns, 63, 0);
    test_random(RandomRuns, 0, 63);
    test_random(RandomRuns, 32, 32);

    // Let any stray result show up before the verdict.
    repeat (TailCycles) @(posedge clk_i);
    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/ilt_pkg.sv
hw/rtl/ilt_store.sv
hw/rtl/ilt_ctrl.sv
hw/rtl/indexed_list_table.sv
hw/rtl/ilt_checker.sv
tb/indexed_list_table_test.sv
